FILE: rtl/dpf_pkg.sv
package dpf_pkg;

  // Default geometry
  localparam int unsigned CACHE_DEPTH_DEF = 16;
  localparam int unsigned ADDR_WIDTH_DEF  = 32;
  localparam int unsigned SEQ_WIDTH_DEF   = 16;

  // Fixed field widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned LIVE_W = 5;

  // Timeout after reset, in ms
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd1000;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_COMMIT = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic start;     // latch item, clear scan accumulators
    logic issue;     // read next entry
    logic commit;    // record item if not a duplicate
    logic load_out;  // move result into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_issue;  // final entry being read
    logic pipe_empty;  // no entry in flight
    logic out_free;    // output register can take a result
  } status_t;

endpackage

FILE: rtl/dpf_in_if.sv
interface dpf_in_if #(
  parameter int unsigned AddrWidth = dpf_pkg::ADDR_WIDTH_DEF,
  parameter int unsigned SeqWidth  = dpf_pkg::SEQ_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic [AddrWidth-1:0]        source_address;
  logic [SeqWidth-1:0]         sequence_number;
  logic [dpf_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, source_address, sequence_number, now_ms, input ready);
  modport sink (input valid, source_address, sequence_number, now_ms, output ready);
  modport monitor (input valid, ready, source_address, sequence_number, now_ms);
endinterface

FILE: rtl/dpf_out_if.sv
interface dpf_out_if ();
  logic                        valid;
  logic                        ready;
  logic                        duplicate;
  logic [dpf_pkg::LIVE_W-1:0]  live_count;

  modport source (output valid, duplicate, live_count, input ready);
  modport sink (input valid, duplicate, live_count, output ready);
  modport monitor (input valid, ready, duplicate, live_count);
endinterface

FILE: rtl/dpf_cfg_if.sv
interface dpf_cfg_if ();
  logic                        valid;
  logic                        ready;
  logic [dpf_pkg::TIME_W-1:0]  timeout_ms;

  modport source (output valid, timeout_ms, input ready);
  modport sink (input valid, timeout_ms, output ready);
  modport monitor (input valid, ready, timeout_ms);
endinterface

FILE: rtl/dpf_ctrl.sv
module dpf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dpf_pkg::status_t status_i,
  output dpf_pkg::cmd_t    cmd_o
);

  dpf_pkg::state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dpf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = dpf_pkg::ST_SCAN;
        end
      end
      dpf_pkg::ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_issue) begin
          state_d = dpf_pkg::ST_DRAIN;
        end
      end
      dpf_pkg::ST_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = dpf_pkg::ST_COMMIT;
        end
      end
      dpf_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = dpf_pkg::ST_DONE;
      end
      dpf_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = dpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/dpf_datapath.sv
module dpf_datapath #(
  parameter int unsigned CACHE_DEPTH = dpf_pkg::CACHE_DEPTH_DEF,
  parameter int unsigned ADDR_WIDTH  = dpf_pkg::ADDR_WIDTH_DEF,
  parameter int unsigned SEQ_WIDTH   = dpf_pkg::SEQ_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dpf_pkg::cmd_t               cmd_i,
  output dpf_pkg::status_t            status_o,
  input  logic                        cfg_valid_i,
  input  logic [dpf_pkg::TIME_W-1:0]  cfg_timeout_i,
  input  logic [ADDR_WIDTH-1:0]       src_i,
  input  logic [SEQ_WIDTH-1:0]        seq_i,
  input  logic [dpf_pkg::TIME_W-1:0]  now_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        out_dup_o,
  output logic [dpf_pkg::LIVE_W-1:0]  out_live_o
);

  localparam int unsigned IDX_W = $clog2(CACHE_DEPTH);
  localparam int unsigned CNT_W = $clog2(CACHE_DEPTH + 1);
  localparam int unsigned TW    = dpf_pkg::TIME_W;

  // Entry store
  logic [ADDR_WIDTH-1:0] mem_src  [CACHE_DEPTH];
  logic [SEQ_WIDTH-1:0]  mem_seq  [CACHE_DEPTH];
  logic [TW-1:0]         mem_time [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] valid_q;

  logic [TW-1:0]         timeout_q;
  logic [ADDR_WIDTH-1:0] src_q;
  logic [SEQ_WIDTH-1:0]  seq_q;
  logic [TW-1:0]         now_q;

  // Scan pipeline: read, age/compare, accumulate
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  vld_a_q, vld_b_q;
  logic [IDX_W-1:0]      idx_a_q, idx_b_q;
  logic [ADDR_WIDTH-1:0] rd_src_q;
  logic [SEQ_WIDTH-1:0]  rd_seq_q;
  logic [TW-1:0]         rd_time_q;
  logic [TW-1:0]         age_b_q;
  logic                  eq_b_q;

  // Accumulators
  logic                  match_q;
  logic                  free_found_q;
  logic [IDX_W-1:0]      free_idx_q;
  logic [TW-1:0]         best_age_q;
  logic [IDX_W-1:0]      best_idx_q;
  logic [CNT_W-1:0]      live_cnt_q;

  logic                  out_valid_q;
  logic                  out_dup_q;
  logic [CNT_W-1:0]      out_cnt_q;

  logic                  cur_valid, expired, live;
  logic [IDX_W-1:0]      slot;
  logic                  record;

  assign cur_valid = valid_q[idx_b_q];
  assign expired   = cur_valid && (age_b_q >= timeout_q);
  assign live      = cur_valid && !expired;
  assign slot      = free_found_q ? free_idx_q : best_idx_q;
  assign record    = cmd_i.commit && !match_q;

  assign status_o.last_issue = cmd_i.issue && (rd_idx_q == IDX_W'(CACHE_DEPTH - 1));
  assign status_o.pipe_empty = !vld_a_q && !vld_b_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_dup_o   = out_dup_q;
  assign out_live_o  = dpf_pkg::LIVE_W'(out_cnt_q);

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= dpf_pkg::TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_timeout_i;
    end
  end

  // Item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      src_q <= src_i;
      seq_q <= seq_i;
      now_q <= now_i;
    end
  end

  // Memory: one write at commit, registered read every cycle
  always_ff @(posedge clk_i) begin
    if (record) begin
      mem_src[slot]  <= src_q;
      mem_seq[slot]  <= seq_q;
      mem_time[slot] <= now_q;
    end
    rd_src_q  <= mem_src[rd_idx_q];
    rd_seq_q  <= mem_seq[rd_idx_q];
    rd_time_q <= mem_time[rd_idx_q];
  end

  // Read address and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      vld_a_q  <= 1'b0;
      vld_b_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.issue) begin
        rd_idx_q <= rd_idx_q + IDX_W'(1);
      end
      vld_a_q <= cmd_i.issue;
      vld_b_q <= vld_a_q;
    end
  end

  // Age and key compare stage
  always_ff @(posedge clk_i) begin
    idx_a_q <= rd_idx_q;
    idx_b_q <= idx_a_q;
    age_b_q <= now_q - rd_time_q;
    eq_b_q  <= (rd_src_q == src_q) && (rd_seq_q == seq_q);
  end

  // Valid bits: expire during scan, set on record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (vld_b_q && expired) begin
        valid_q[idx_b_q] <= 1'b0;
      end
      if (record) begin
        valid_q[slot] <= 1'b1;
      end
    end
  end

  // Scan accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      match_q      <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      best_age_q   <= '0;
      best_idx_q   <= '0;
      live_cnt_q   <= '0;
    end else if (vld_b_q) begin
      if (live && eq_b_q) begin
        match_q <= 1'b1;
      end
      if (live) begin
        live_cnt_q <= live_cnt_q + CNT_W'(1);
      end
      // lowest free slot
      if (!live && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= idx_b_q;
      end
      // oldest entry, ties to lowest index
      if (idx_b_q == '0 || age_b_q > best_age_q) begin
        best_age_q <= age_b_q;
        best_idx_q <= idx_b_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_dup_q <= match_q;
      out_cnt_q <= (!match_q && free_found_q) ? live_cnt_q + CNT_W'(1) : live_cnt_q;
    end
  end

endmodule

FILE: rtl/duplicate_packet_filter.sv
// Channel   Dir  Payload                                           Handshake
// pkt_i     in   source_address, sequence_number, now_ms           valid/ready
// res_o     out  duplicate, live_count                             valid/ready
// cfg_i     in   timeout_ms                                        valid/ready
//
// From accept to result, an item is handled by a scan that reads one cache
// entry per cycle from the entry memory.
// One item is in work at a time; pkt_i.ready is high only while idle.
// A finished result waits in the output register; a stalled res_o holds the
// scan engine at its end. cfg_i is always ready.
// Reset clears the valid marks at once; no clearing pass is needed.
module duplicate_packet_filter #(
  parameter int unsigned CACHE_DEPTH    = dpf_pkg::CACHE_DEPTH_DEF,
  parameter int unsigned ADDRESS_WIDTH  = dpf_pkg::ADDR_WIDTH_DEF,
  parameter int unsigned SEQUENCE_WIDTH = dpf_pkg::SEQ_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpf_in_if.sink    pkt_i,
  dpf_out_if.source res_o,
  dpf_cfg_if.sink   cfg_i
);

  dpf_pkg::cmd_t    cmd;
  dpf_pkg::status_t status;

  assign cfg_i.ready = 1'b1;

  dpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pkt_i.valid),
    .in_ready_o (pkt_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dpf_datapath #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .ADDR_WIDTH  (ADDRESS_WIDTH),
    .SEQ_WIDTH   (SEQUENCE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_timeout_i (cfg_i.timeout_ms),
    .src_i         (pkt_i.source_address),
    .seq_i         (pkt_i.sequence_number),
    .now_i         (pkt_i.now_ms),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .out_dup_o     (res_o.duplicate),
    .out_live_o    (res_o.live_count)
  );

endmodule

FILE: rtl/dpf_checker.sv
module dpf_checker #(
  parameter int unsigned CacheDepth = dpf_pkg::CACHE_DEPTH_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        pkt_valid_i,
  input logic                        pkt_ready_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic                        res_dup_i,
  input logic [dpf_pkg::LIVE_W-1:0]  res_live_i
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_dup_i)
      && $stable(res_live_i))
    else $error("result dropped or changed while stalled");

  // One item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_i && pkt_ready_i |=> !pkt_ready_i)
    else $error("input taken while an item is in work");

  // Live count never above the cache depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (CacheDepth >= 32) || (res_live_i <= CacheDepth))
    else $error("live count above cache depth");

  // A recorded item is itself live
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_dup_i |-> (CacheDepth >= 32) || (res_live_i != '0))
    else $error("recorded item but no live entry");

endmodule

bind duplicate_packet_filter dpf_checker #(
  .CacheDepth (CACHE_DEPTH)
) u_dpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pkt_valid_i (pkt_i.valid),
  .pkt_ready_i (pkt_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_dup_i   (res_o.duplicate),
  .res_live_i  (res_o.live_count)
);

FILE: dv/duplicate_packet_filter_test.sv
module duplicate_packet_filter_test;

  localparam int unsigned Depth = dpf_pkg::CACHE_DEPTH_DEF;

  typedef logic [dpf_pkg::ADDR_WIDTH_DEF-1:0] addr_t;
  typedef logic [dpf_pkg::SEQ_WIDTH_DEF-1:0]  seq_t;
  typedef logic [dpf_pkg::TIME_W-1:0]         ms_t;

  typedef struct packed {
    logic                       duplicate;
    logic [dpf_pkg::LIVE_W-1:0] live_count;
  } filter_result_t;

  logic clk_i;
  logic rst_ni;

  dpf_in_if  pkt_if ();
  dpf_out_if res_if ();
  dpf_cfg_if cfg_if ();

  duplicate_packet_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pkt_i  (pkt_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Predicted cache contents and timeout
  logic  slot_live [Depth];
  addr_t slot_source [Depth];
  seq_t  slot_sequence [Depth];
  ms_t   slot_stamp [Depth];
  ms_t   timeout_model;

  filter_result_t pending_results[$];
  int             mismatch_count;
  int             sender_idle_pct;
  int             recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Expire, look up, then record; returns the verdict and the live count
  function automatic filter_result_t filter_packet(input addr_t addr, input seq_t seqn,
                                                   input ms_t now);
    filter_result_t res;
    ms_t            age;
    ms_t            max_age;
    int unsigned    slot;
    int unsigned    count;
    bit             found;
    res.duplicate = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      age = now - slot_stamp[i];
      if (slot_live[i] && age >= timeout_model) slot_live[i] = 1'b0;
    end
    for (int i = 0; i < Depth; i++) begin
      if (slot_live[i] && slot_sequence[i] == seqn && slot_source[i] == addr) begin
        res.duplicate = 1'b1;
      end
    end
    if (!res.duplicate) begin
      found = 1'b0;
      slot  = 0;
      for (int i = 0; i < Depth; i++) begin
        if (!found && !slot_live[i]) begin
          slot  = i;
          found = 1'b1;
        end
      end
      // Cache full: replace the oldest, lowest index on a tie
      if (!found) begin
        max_age = now - slot_stamp[0];
        for (int i = 1; i < Depth; i++) begin
          age = now - slot_stamp[i];
          if (age > max_age) begin
            max_age = age;
            slot    = i;
          end
        end
      end
      slot_source[slot]   = addr;
      slot_sequence[slot] = seqn;
      slot_stamp[slot]    = now;
      slot_live[slot]     = 1'b1;
    end
    count = 0;
    for (int i = 0; i < Depth; i++) begin
      if (slot_live[i]) count++;
    end
    res.live_count = count[dpf_pkg::LIVE_W-1:0];
    return res;
  endfunction

  // Receiver stalls and result checking
  always @(posedge clk_i) begin : result_check
    filter_result_t want;
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual duplicate %0d live_count %0d",
                 $time, res_if.duplicate, res_if.live_count);
      end else begin
        want = pending_results.pop_front();
        if (res_if.duplicate !== want.duplicate) begin
          mismatch_count++;
          $display("%0t: duplicate expected %0d actual %0d",
                   $time, want.duplicate, res_if.duplicate);
        end
        if (res_if.live_count !== want.live_count) begin
          mismatch_count++;
          $display("%0t: live_count expected %0d actual %0d",
                   $time, want.live_count, res_if.live_count);
        end
      end
    end
  end

  // Offer one packet; valid stays high when the next one follows at once
  task automatic send_packet(input addr_t addr, input seq_t seqn, input ms_t now);
    if ($urandom_range(99) < sender_idle_pct) begin
      pkt_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    pkt_if.valid           <= 1'b1;
    pkt_if.source_address  <= addr;
    pkt_if.sequence_number <= seqn;
    pkt_if.now_ms          <= now;
    do @(posedge clk_i); while (!pkt_if.ready);
    pending_results.push_back(filter_packet(addr, seqn, now));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    pkt_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_timeout(input ms_t value);
    drain_results();
    cfg_if.valid      <= 1'b1;
    cfg_if.timeout_ms <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid  <= 1'b0;
    timeout_model = value;
  endtask

  // Reset timeout of 1000: an entry lives while its age is below it
  task automatic test_expiry_boundary();
    send_packet(32'h0A00_0001, 16'h1234, 32'd100);
    send_packet(32'h0A00_0001, 16'h1234, 32'd1099);
    send_packet(32'h0A00_0001, 16'h1234, 32'd1100);
    send_packet(32'h0A00_0001, 16'h1235, 32'd1100);
    send_packet(32'h0A00_0002, 16'h1234, 32'd1100);
  endtask

  // All-zero and all-one fields, clock wrap and time running backwards
  task automatic test_field_extremes();
    write_timeout('1);
    send_packet('0, '0, '0);
    send_packet('1, '1, '1);
    send_packet('0, '0, '1);
    send_packet('1, '1, 32'hFFFF_FFFE);
  endtask

  // Zero timeout expires everything on every packet
  task automatic test_zero_timeout();
    write_timeout('0);
    send_packet(32'h1111_2222, 16'h0042, 32'd5000);
    send_packet(32'h1111_2222, 16'h0042, 32'd5000);
  endtask

  // Full cache where every entry has the same age: slot 0 is replaced
  task automatic test_tie_eviction();
    write_timeout(32'd1);
    for (int k = 0; k <= Depth; k++) begin
      send_packet(32'hC0A8_0000 + k, seq_t'(k * 3), 32'h8000_0000);
    end
  endtask

  // Mostly packets from a small key pool on a steadily running clock,
  // some fully random noise and some steps back in time
  task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct,
                                     input ms_t tmo, input int step_max);
    addr_t src_pool [8];
    seq_t  seq_pool [8];
    ms_t   clock_ms;
    int    pick;
    write_timeout(tmo);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    for (int k = 0; k < 8; k++) begin
      src_pool[k] = $urandom;
      seq_pool[k] = seq_t'($urandom);
    end
    clock_ms = $urandom;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        clock_ms = clock_ms + ms_t'($urandom_range(step_max));
        send_packet(src_pool[$urandom_range(7)], seq_pool[$urandom_range(7)], clock_ms);
      end else if (pick < 90) begin
        send_packet($urandom, seq_t'($urandom), $urandom);
      end else begin
        clock_ms = clock_ms - ms_t'($urandom_range(1, 3 * step_max + 1));
        send_packet(src_pool[$urandom_range(7)], seq_pool[$urandom_range(7)], clock_ms);
      end
    end
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
  endtask

  initial begin : stimulus
    ms_t rand_tmo;
    rst_ni                 <= 1'b0;
    pkt_if.valid           <= 1'b0;
    pkt_if.source_address  <= '0;
    pkt_if.sequence_number <= '0;
    pkt_if.now_ms          <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.timeout_ms      <= '0;
    mismatch_count  = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    timeout_model   = dpf_pkg::TIMEOUT_RST;
    for (int i = 0; i < Depth; i++) begin
      slot_live[i] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_expiry_boundary();
    test_field_extremes();
    test_zero_timeout();
    test_tie_eviction();

    // Random phases: no idling, sender idle, receiver stalling, both a little
    test_random_traffic(130, 0, 0, 32'd60, 12);
    test_random_traffic(130, 83, 0, '1, 3);
    test_random_traffic(130, 0, 83, 32'd1, 1);
    rand_tmo = ms_t'($urandom_range(20, 400));
    test_random_traffic(130, 10, 10, rand_tmo, int'(rand_tmo / 8));

    drain_results();
    repeat (2 * Depth + 8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0t: results expected %0d more actual 0", $time, pending_results.size());
    end
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
